// ===== design/kuf_pkg.sv =====
// ---------------------------------------------------------------------------
// kuf_pkg: shared types and constants for the union-find edge stream
// Widths, limits and the sequencer state type.
// ---------------------------------------------------------------------------
package kuf_pkg;

	localparam int unsigned VERTEX_COUNT_DEF = 1024;
	localparam int unsigned WEIGHT_BITS_DEF  = 16;
	localparam int unsigned VTX_W            = 10;
	localparam int unsigned WIN_W            = 16;
	localparam int unsigned TOTAL_W          = 26;
	localparam int unsigned COUNT_W          = 10;
	localparam int unsigned RANK_W           = 4;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [RANK_W-1:0]  RANK_MAX  = '1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_WALK,
		ST_CRD,
		ST_CWALK,
		ST_JOIN,
		ST_DONE
	} kuf_state_t;

	// memory access request from sequencer
	typedef struct packed {
		logic             rd;
		logic             wr_par;
		logic             wr_rank;
		logic [VTX_W-1:0] addr;
		logic [VTX_W-1:0] par_d;
		logic [RANK_W-1:0] rank_d;
	} kuf_mem_req_t;

endpackage

// ===== design/kruskal_union_find_edge_stream_top.sv =====
// For each endpoint in turn, RD and WALK follow parent links to the root, then CRD and
//   CWALK point every vertex on that path at the root; JOIN and DONE follow.
// An edge with an endpoint out of range goes from RD straight to DONE.
// One edge at a time: once the result loads into its output register, the next edge
//   is taken while the result waits there.
// Reset and every last edge start a clearing pass over all vertex entries, during which no edge is accepted.
// ---------------------------------------------------------------------------
// kruskal_union_find_edge_stream_top: streaming Kruskal union-find
// Finds roots with path compression, merges by rank, keeps tree totals.
// ---------------------------------------------------------------------------
module kruskal_union_find_edge_stream_top
	import kuf_pkg::*;
#(
	parameter int unsigned VERTEX_COUNT = VERTEX_COUNT_DEF,
	parameter int unsigned WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [VTX_W-1:0]   vertex_a,
	input  logic [VTX_W-1:0]   vertex_b,
	input  logic [WIN_W-1:0]   edge_weight,
	input  logic               last_edge,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               edge_taken,
	output logic [TOTAL_W-1:0] tree_weight,
	output logic [COUNT_W-1:0] tree_edges,
	output logic               tree_final
);

	localparam logic [VTX_W:0] VC = (VTX_W+1)'(VERTEX_COUNT > 1024 ? 1024 : VERTEX_COUNT);

	kuf_state_t state_q, state_d;
	kuf_mem_req_t req;
	logic [VTX_W-1:0]  par_q;
	logic [RANK_W-1:0] rank_q;

	logic [VTX_W:0]    clr_q;
	logic [VTX_W-1:0]  a_q, b_q, v_q, root_q, ra_q, rb_q;
	logic [RANK_W-1:0] rka_q, rkb_q;
	logic [WIN_W-1:0]  w_q;
	logic              last_q, side_q, taken_q;
	logic [TOTAL_W-1:0] total_q;
	logic [COUNT_W-1:0] count_q;
	logic [WIN_W-1:0]  wm;
	logic [TOTAL_W:0]  sum;

	kuf_mem #(.VERTEX_COUNT(VERTEX_COUNT)) u_mem (
		.clk(clk), .req(req), .par_q(par_q), .rank_q(rank_q)
	);

	assign wm  = (WEIGHT_BITS >= WIN_W) ? w_q :
		(w_q & WIN_W'((32'd1 << WEIGHT_BITS) - 32'd1));
	assign sum = {1'b0, total_q} + (TOTAL_W+1)'(wm);

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d    = state_q;
		req        = '0;
		unique case (state_q)
			ST_CLEAR: begin
				req.addr    = clr_q[VTX_W-1:0];
				req.par_d   = clr_q[VTX_W-1:0];
				req.wr_par  = 1'b1;
				req.wr_rank = 1'b1;
				if (clr_q == VC - 1'b1)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid && in_ready)
					state_d = ST_RD;
			end
			ST_RD: begin
				if ({1'b0, a_q} >= VC || {1'b0, b_q} >= VC)
					state_d = ST_DONE;
				else begin
					req.rd   = 1'b1;
					req.addr = v_q;
					state_d  = ST_WALK;
				end
			end
			ST_WALK: begin
				if (par_q == v_q)
					state_d = ST_CRD;
				else begin
					req.rd   = 1'b1;
					req.addr = par_q;
					state_d  = ST_WALK;
				end
			end
			ST_CRD: begin
				if (v_q == root_q) begin
					if (side_q)
						state_d = ST_JOIN;
					else
						state_d = ST_RD;
				end else begin
					req.rd   = 1'b1;
					req.addr = v_q;
					state_d  = ST_CWALK;
				end
			end
			ST_CWALK: begin
				req.wr_par = 1'b1;
				req.addr   = v_q;
				req.par_d  = root_q;
				state_d    = ST_CRD;
			end
			ST_JOIN: begin
				if (ra_q == rb_q)
					state_d = ST_DONE;
				else begin
					req.addr = (rka_q > rkb_q) ? rb_q : ra_q;
					req.par_d = (rka_q > rkb_q) ? ra_q : rb_q;
					req.wr_par = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid || out_ready)
					state_d = last_q ? ST_CLEAR : ST_IDLE;
				if (taken_q && !(rka_q > rkb_q) && rka_q == rkb_q && rkb_q < RANK_MAX) begin
					req.wr_rank = 1'b1;
					req.addr    = rb_q;
					req.rank_d  = rkb_q + 1'b1;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			out_valid <= 1'b0;
			total_q   <= '0;
			count_q   <= '0;
			taken_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && (!out_valid || out_ready))
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= (state_d == ST_IDLE) ? '0 : clr_q + 1'b1;
					total_q <= '0;
					count_q <= '0;
				end
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						a_q     <= vertex_a;
						b_q     <= vertex_b;
						v_q     <= vertex_a;
						w_q     <= edge_weight;
						last_q  <= last_edge;
						side_q  <= 1'b0;
						taken_q <= 1'b0;
					end
				end
				ST_RD: begin
					// v_q holds the start vertex of the current find
				end
				ST_WALK: begin
					if (par_q == v_q) begin
						root_q <= v_q;
						v_q    <= side_q ? b_q : a_q;
						if (side_q) begin
							rb_q  <= v_q;
							rkb_q <= rank_q;
						end else begin
							ra_q <= v_q;
							rka_q <= rank_q;
						end
					end else
						v_q <= par_q;
				end
				ST_CRD: begin
					if (v_q == root_q && !side_q) begin
						side_q <= 1'b1;
						v_q    <= b_q;
					end
				end
				ST_CWALK: begin
					v_q <= par_q;
				end
				ST_JOIN: begin
					if (ra_q != rb_q) begin
						taken_q <= 1'b1;
						total_q <= sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
						if (count_q != COUNT_MAX)
							count_q <= count_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (!out_valid || out_ready) begin
						edge_taken  <= taken_q;
						tree_weight <= total_q;
						tree_edges  <= count_q;
						tree_final  <= last_q;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== design/kuf_mem.sv =====
// ---------------------------------------------------------------------------
// kuf_mem: parent and rank tables
// Single-port synchronous memory with a registered read.
// ---------------------------------------------------------------------------
module kuf_mem
	import kuf_pkg::*;
#(
	parameter int unsigned VERTEX_COUNT = VERTEX_COUNT_DEF,
	localparam int unsigned DEPTH = (VERTEX_COUNT > (1 << VTX_W)) ? (1 << VTX_W) : VERTEX_COUNT,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic               clk,
	input  kuf_mem_req_t       req,
	output logic [VTX_W-1:0]   par_q,
	output logic [RANK_W-1:0]  rank_q
);

	logic [VTX_W-1:0]  par_mem  [DEPTH];
	logic [RANK_W-1:0] rank_mem [DEPTH];
	logic [AW-1:0]     a;

	assign a = req.addr[AW-1:0];

	always_ff @(posedge clk) begin
		if (req.wr_par)
			par_mem[a] <= req.par_d;
		if (req.wr_rank)
			rank_mem[a] <= req.rank_d;
		if (req.rd) begin
			par_q  <= par_mem[a];
			rank_q <= rank_mem[a];
		end
	end

endmodule

// ===== tb/sv/kruskal_union_find_edge_stream_top_tb.sv =====
// ---------------------------------------------------------------------------
// kruskal_union_find_edge_stream_top_tb: union-find edge stream testbench
// Directed table, a long chain, then random graphs; every result beat is checked against a
// disjoint-set predictor kept in step with the accepted edges.
// ---------------------------------------------------------------------------
module kruskal_union_find_edge_stream_top_tb;
	import kuf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NVTX = VERTEX_COUNT_DEF;
	localparam int          STALL_LIMIT = 20000;
	localparam int          NDIR = 12;

	typedef struct packed {
		logic               taken;
		logic [TOTAL_W-1:0] wsum;
		logic [COUNT_W-1:0] cnt;
		logic               fin;
	} tree_res_t;

	typedef struct {
		logic [VTX_W-1:0] a;
		logic [VTX_W-1:0] b;
		logic [WIN_W-1:0] w;
		logic             last;
		bit               has_res;
		tree_res_t        res;
	} edge_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [VTX_W-1:0] vertex_a = '0;
	logic [VTX_W-1:0] vertex_b = '0;
	logic [WIN_W-1:0] edge_weight = '0;
	logic last_edge = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic edge_taken;
	logic [TOTAL_W-1:0] tree_weight;
	logic [COUNT_W-1:0] tree_edges;
	logic tree_final;

	logic [VTX_W-1:0]   forest_parent [NVTX];
	logic [RANK_W-1:0]  forest_rank [NVTX];
	logic [TOTAL_W-1:0] mst_weight;
	logic [COUNT_W-1:0] mst_count;

	tree_res_t pending_totals[$];
	int errors = 0;
	int idle_cycles = 0;
	bit rx_hold = 1'b0;

	kruskal_union_find_edge_stream_top DUT (.*);

	always #10 clk = ~clk;

	function automatic void forest_clear();
		for (int i = 0; i < NVTX; i++) begin
			forest_parent[i] = i[VTX_W-1:0];
			forest_rank[i] = '0;
		end
		mst_weight = '0;
		mst_count = '0;
	endfunction

	function automatic logic [VTX_W-1:0] forest_root(logic [VTX_W-1:0] v);
		logic [VTX_W-1:0] r, nx;
		r = v;
		while (forest_parent[r] != r) r = forest_parent[r];
		while (v != r) begin
			nx = forest_parent[v];
			forest_parent[v] = r;
			v = nx;
		end
		return r;
	endfunction

	function automatic tree_res_t mst_step(logic [VTX_W-1:0] a, logic [VTX_W-1:0] b,
			logic [WIN_W-1:0] w, logic last);
		tree_res_t r;
		logic [VTX_W-1:0] ra, rb;
		logic [TOTAL_W:0] s;
		r.taken = 1'b0;
		ra = forest_root(a);
		rb = forest_root(b);
		if (ra != rb) begin
			r.taken = 1'b1;
			s = {1'b0, mst_weight} + (TOTAL_W+1)'(w);
			mst_weight = s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
			if (mst_count != COUNT_MAX) mst_count++;
			if (forest_rank[ra] > forest_rank[rb]) forest_parent[rb] = ra;
			else begin
				forest_parent[ra] = rb;
				if (forest_rank[ra] == forest_rank[rb] && forest_rank[rb] != RANK_MAX)
					forest_rank[rb]++;
			end
		end
		r.wsum = mst_weight;
		r.cnt = mst_count;
		r.fin = last;
		if (last) forest_clear();
		return r;
	endfunction

	task automatic send_edge(edge_row_t e);
		tree_res_t r;
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 :
			(($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3));
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		vertex_a <= e.a;
		vertex_b <= e.b;
		edge_weight <= e.w;
		last_edge <= e.last;
		do @(posedge clk); while (!in_ready);
		r = mst_step(e.a, e.b, e.w, e.last);
		if (e.has_res && r !== e.res) begin
			$display("%0t table row mismatch: expected %h got predictor %h", $time, e.res, r);
			errors++;
		end
		pending_totals.insert(pending_totals.size(), r);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_totals.size() != 0);
	endtask

	// receiver side
	always @(posedge clk) begin
		tree_res_t g, x;
		if (arst_n) begin
			if (in_valid && in_ready || out_valid && out_ready) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (out_valid && out_ready) begin
				g = '{edge_taken, tree_weight, tree_edges, tree_final};
				if (pending_totals.size() == 0) begin
					$display("%0t unexpected result %h", $time, g);
					errors++;
				end else begin
					x = pending_totals.pop_front();
					if (g.taken !== x.taken)
						$display("%0t edge_taken expected %b actual %b", $time, x.taken, g.taken);
					if (g.wsum !== x.wsum)
						$display("%0t tree_weight expected %0d actual %0d", $time, x.wsum, g.wsum);
					if (g.cnt !== x.cnt)
						$display("%0t tree_edges expected %0d actual %0d", $time, x.cnt, g.cnt);
					if (g.fin !== x.fin)
						$display("%0t tree_final expected %b actual %b", $time, x.fin, g.fin);
					if (g !== x) errors++;
				end
			end
			if (rx_hold) out_ready <= 1'b0;
			else if ($urandom_range(0, 3) == 0) out_ready <= 1'b0;
			else out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		edge_row_t dir[NDIR];
		edge_row_t e;
		int nsent, nv, span;
		forest_clear();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// first edge after reset, extremes, self-loop, cycle, last edge
		dir[0]  = '{10'd0, 10'd1023, 16'hFFFF, 1'b0, 1'b1, '{1'b1, 26'd65535, 10'd1, 1'b0}};
		dir[1]  = '{10'd5, 10'd5, 16'd7, 1'b0, 1'b1, '{1'b0, 26'd65535, 10'd1, 1'b0}};
		dir[2]  = '{10'd1023, 10'd0, 16'd0, 1'b0, 1'b1, '{1'b0, 26'd65535, 10'd1, 1'b0}};
		dir[3]  = '{10'd1, 10'd2, 16'd0, 1'b0, 1'b1, '{1'b1, 26'd65535, 10'd2, 1'b0}};
		dir[4]  = '{10'd2, 10'd3, 16'd3, 1'b0, 1'b0, '0};
		dir[5]  = '{10'd3, 10'd1, 16'd4, 1'b0, 1'b0, '0};
		dir[6]  = '{10'd0, 10'd3, 16'hFFFF, 1'b0, 1'b0, '0};
		dir[7]  = '{10'd512, 10'd511, 16'h8000, 1'b0, 1'b0, '0};
		dir[8]  = '{10'd3, 10'd511, 16'h5555, 1'b0, 1'b0, '0};
		dir[9]  = '{10'd1023, 10'd1023, 16'hAAAA, 1'b1, 1'b0, '0};
		dir[10] = '{10'd1023, 10'd1022, 16'd9, 1'b1, 1'b1, '{1'b1, 26'd9, 10'd1, 1'b1}};
		dir[11] = '{10'd1022, 10'd1023, 16'd1, 1'b0, 1'b1, '{1'b1, 26'd1, 10'd1, 1'b0}};
		foreach (dir[i]) send_edge(dir[i]);
		// long chain: deep walks, rank growth, edge count up to its maximum
		for (int i = 0; i < 1023; i++) begin
			e = '{i[VTX_W-1:0], (i == 1022) ? 10'd1023 : i[VTX_W-1:0] + 10'd1,
				16'hFFFF, 1'b0, 1'b0, '0};
			send_edge(e);
			if (i % 64 == 63)
				send_edge('{VTX_W'($urandom), VTX_W'($urandom), WIN_W'($urandom),
					1'b0, 1'b0, '0});
		end
		send_edge('{10'd0, 10'd700, 16'hFFFF, 1'b1, 1'b0, '0});
		drain();
		// random graphs; span shapes how dense the sets get
		nsent = 0;
		while (nsent < 450) begin
			nv = $urandom_range(2, 6) * (($urandom_range(0, 7) == 0) ? 64 : 1);
			span = $urandom_range(3, 60);
			for (int k = 0; k < span; k++) begin
				e.a = ($urandom_range(0, 15) == 0) ? VTX_W'($urandom) :
					VTX_W'($urandom_range(0, nv - 1));
				e.b = ($urandom_range(0, 15) == 0) ? VTX_W'($urandom) :
					VTX_W'($urandom_range(0, nv - 1));
				e.w = ($urandom_range(0, 3) == 0) ? 16'hFFFF : WIN_W'($urandom);
				e.last = (k == span - 1);
				e.has_res = 1'b0;
				send_edge(e);
				nsent++;
			end
			if ($urandom_range(0, 9) == 0) begin
				in_valid <= 1'b0;
				rx_hold = 1'b1;
				repeat ($urandom_range(20, 80)) @(posedge clk);
				rx_hold = 1'b0;
			end
			if ($urandom_range(0, 14) == 0) drain();
		end
		drain();
		repeat (100) @(posedge clk);
		if (errors == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end
endmodule

// ===== filelist.f =====
design/kuf_pkg.sv
design/kuf_mem.sv
design/kruskal_union_find_edge_stream_top.sv
tb/sv/kruskal_union_find_edge_stream_top_tb.sv
